FILE: design/lrts_pkg.sv
package lrts_pkg;

  // Default table size and fixed field widths
  localparam int TASK_SLOTS_DEF = 16;
  localparam int TICK_W         = 64;
  localparam int OP_W           = 3;
  localparam int HANDLE_W       = 4;
  localparam int STATUS_W       = 2;
  localparam int TASK_W         = 4;

  // Event codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_YIELD   = 3'd1,
    OP_CREATE  = 3'd2,
    OP_SUSPEND = 3'd3,
    OP_RESUME  = 3'd4,
    OP_KILL    = 3'd5
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_BAD_HANDLE = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RM_RD,
    S_RM_WR,
    S_PUSH1,
    S_PUSH2,
    S_PK_START,
    S_PK_RD,
    S_PK_CMP,
    S_PK_END,
    S_RESP
  } state_t;

  // Where the sequencer goes after a list removal
  typedef enum logic [1:0] {
    C_PUSH,
    C_FREE,
    C_PICK
  } cont_t;

endpackage

FILE: design/least_recent_task_scheduler.sv
// Least-recently-run task scheduler. One transaction in gives one result out.
// Tick and yield walk the running list through the link and tick memories,
// a memory read and then a compare for each listed task, before the result;
// a pick that frees a terminating task adds an unlink and walks the list again.
// Create does two push-front writes, then the result; suspend and resume do an
// unlink plus a push-front; a kill of a running-list task does an unlink; other
// kills, bad handles, full-table creates and unknown codes go straight to the
// result. The next transaction is taken once the result has moved into the
// output register; that move waits while out_stall holds an earlier result.
// Memories need no clearing after reset: every entry is written before it can
// be read. A finished result waits in the output register while the next
// transaction is taken.
module least_recent_task_scheduler #(
  parameter int TASK_SLOTS = lrts_pkg::TASK_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lrts_pkg::OP_W-1:0]     operation,
  input  logic [lrts_pkg::HANDLE_W-1:0] handle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lrts_pkg::STATUS_W-1:0] status,
  output logic                          switched,
  output logic [lrts_pkg::TASK_W-1:0]   chosen_task,
  output logic [lrts_pkg::TASK_W-1:0]   created_task,
  output logic                          freed_valid,
  output logic [lrts_pkg::TASK_W-1:0]   freed_task
);

  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int LW = $clog2(TASK_SLOTS + 1);
  localparam int TW = lrts_pkg::TICK_W;
  localparam logic [LW-1:0] END_LINK = LW'(TASK_SLOTS);

  lrts_pkg::state_t state, state_next;

  // Per-slot flags
  logic [TASK_SLOTS-1:0] slot_used, is_susp, is_term;
  logic [LW-1:0]         running_first, suspended_first;
  logic [TW-1:0]         tick_total;

  // Working registers of the current transaction
  logic [lrts_pkg::OP_W-1:0] op_q;
  logic [SW-1:0]             target;
  logic                      list_susp, push_susp, pass;
  lrts_pkg::cont_t           cont;
  logic [LW-1:0]             node;
  logic                      found;
  logic [SW-1:0]             best;
  logic [TW-1:0]             best_tick;
  logic [lrts_pkg::STATUS_W-1:0] r_status;
  logic                      r_switched, r_fvalid;
  logic [SW-1:0]             r_chosen, r_created, r_freed;

  // Memory ports
  logic          tk_we, nx_we, pv_we;
  logic [SW-1:0] tk_waddr, nx_waddr, pv_waddr, tk_raddr, nx_raddr, pv_raddr;
  logic [TW-1:0] tk_wdata, tk_rdata;
  logic [LW-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;

  lrts_ram #(.DEPTH(TASK_SLOTS), .AW(SW), .DW(TW)) u_tick_ram (
    .clk(clk), .we(tk_we), .waddr(tk_waddr), .wdata(tk_wdata),
    .raddr(tk_raddr), .rdata(tk_rdata)
  );
  lrts_ram #(.DEPTH(TASK_SLOTS), .AW(SW), .DW(LW)) u_next_ram (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata)
  );
  lrts_ram #(.DEPTH(TASK_SLOTS), .AW(SW), .DW(LW)) u_prev_ram (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(pv_raddr), .rdata(pv_rdata)
  );

  // Lowest free slot
  logic          free_found;
  logic [SW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // Handle check and decode helpers
  logic          in_acc, h_ok;
  logic [SW-1:0] h_slot;
  logic [LW-1:0] rm_first, push_first, tgt_link;
  logic [SW-1:0] pick_slot;
  assign in_acc     = in_valid && !in_stall;
  assign h_slot     = SW'(handle);
  assign h_ok       = (handle != '0) && (32'(handle) < TASK_SLOTS) && slot_used[h_slot];
  assign rm_first   = list_susp ? suspended_first : running_first;
  assign push_first = push_susp ? suspended_first : running_first;
  assign tgt_link   = LW'(target);
  assign pick_slot  = found ? best : '0;
  assign in_stall   = (state != lrts_pkg::S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory control
  always_comb begin
    state_next = state;
    tk_we = 1'b0; tk_waddr = target; tk_wdata = '0; tk_raddr = SW'(node);
    nx_we = 1'b0; nx_waddr = target; nx_wdata = '0; nx_raddr = target;
    pv_we = 1'b0; pv_waddr = target; pv_wdata = '0; pv_raddr = target;
    unique case (state)
      lrts_pkg::S_IDLE: begin
        if (in_acc) begin
          case (operation)
            lrts_pkg::OP_TICK, lrts_pkg::OP_YIELD: state_next = lrts_pkg::S_PK_START;
            lrts_pkg::OP_CREATE:
              state_next = free_found ? lrts_pkg::S_PUSH1 : lrts_pkg::S_RESP;
            lrts_pkg::OP_SUSPEND:
              state_next = (h_ok && !is_susp[h_slot]) ? lrts_pkg::S_RM_RD : lrts_pkg::S_RESP;
            lrts_pkg::OP_RESUME:
              state_next = (h_ok && is_susp[h_slot]) ? lrts_pkg::S_RM_RD : lrts_pkg::S_RESP;
            lrts_pkg::OP_KILL:
              state_next = (h_ok && !is_susp[h_slot]) ? lrts_pkg::S_RM_RD : lrts_pkg::S_RESP;
            default: state_next = lrts_pkg::S_RESP;
          endcase
        end
      end
      lrts_pkg::S_RM_RD: begin
        state_next = lrts_pkg::S_RM_WR;
      end
      lrts_pkg::S_RM_WR: begin
        nx_we    = (pv_rdata != END_LINK);
        nx_waddr = SW'(pv_rdata);
        nx_wdata = nx_rdata;
        pv_we    = (nx_rdata != END_LINK);
        pv_waddr = SW'(nx_rdata);
        pv_wdata = pv_rdata;
        unique case (cont)
          lrts_pkg::C_PUSH: state_next = lrts_pkg::S_PUSH1;
          lrts_pkg::C_FREE: state_next = lrts_pkg::S_RESP;
          default:          state_next = lrts_pkg::S_PK_START;
        endcase
      end
      lrts_pkg::S_PUSH1: begin
        nx_we    = 1'b1;
        nx_wdata = push_first;
        pv_we    = 1'b1;
        pv_wdata = END_LINK;
        tk_we    = (op_q == lrts_pkg::OP_CREATE);
        tk_wdata = '0;
        state_next = lrts_pkg::S_PUSH2;
      end
      lrts_pkg::S_PUSH2: begin
        pv_we    = (push_first != END_LINK);
        pv_waddr = SW'(push_first);
        pv_wdata = tgt_link;
        state_next = lrts_pkg::S_RESP;
      end
      lrts_pkg::S_PK_START: begin
        state_next = lrts_pkg::S_PK_RD;
      end
      lrts_pkg::S_PK_RD: begin
        nx_raddr = SW'(node);
        state_next = (node == END_LINK) ? lrts_pkg::S_PK_END : lrts_pkg::S_PK_CMP;
      end
      lrts_pkg::S_PK_CMP: begin
        state_next = lrts_pkg::S_PK_RD;
      end
      lrts_pkg::S_PK_END: begin
        if (is_term[pick_slot] && !pass) begin
          state_next = lrts_pkg::S_RM_RD;
        end else begin
          tk_we      = 1'b1;
          tk_waddr   = pick_slot;
          tk_wdata   = tick_total;
          state_next = lrts_pkg::S_RESP;
        end
      end
      lrts_pkg::S_RESP: begin
        if (!out_valid || !out_stall) begin
          state_next = lrts_pkg::S_IDLE;
        end
      end
      default: state_next = lrts_pkg::S_IDLE;
    endcase
  end

  // Control state: flags, list heads, tick counter
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used       <= TASK_SLOTS'(1);
      is_susp         <= '0;
      is_term         <= '0;
      running_first   <= END_LINK;
      suspended_first <= END_LINK;
      tick_total      <= '0;
    end else begin
      case (state)
        lrts_pkg::S_IDLE: begin
          if (in_acc) begin
            if (operation == lrts_pkg::OP_TICK) begin
              tick_total <= tick_total + TW'(1);
            end
            if (operation == lrts_pkg::OP_CREATE && free_found) begin
              slot_used[free_idx] <= 1'b1;
              is_susp[free_idx]   <= 1'b0;
              is_term[free_idx]   <= 1'b0;
            end
            if (operation == lrts_pkg::OP_KILL && h_ok && is_susp[h_slot]) begin
              is_term[h_slot] <= 1'b1;
            end
          end
        end
        lrts_pkg::S_RM_WR: begin
          if (rm_first == tgt_link) begin
            if (list_susp) suspended_first <= nx_rdata;
            else           running_first   <= nx_rdata;
          end
          if (cont != lrts_pkg::C_PUSH) begin
            slot_used[target] <= 1'b0;
            is_susp[target]   <= 1'b0;
            is_term[target]   <= 1'b0;
          end
        end
        lrts_pkg::S_PUSH2: begin
          if (push_susp) suspended_first <= tgt_link;
          else           running_first   <= tgt_link;
          is_susp[target] <= push_susp;
        end
        default: ;
      endcase
    end
  end

  // Transaction working registers and result fields
  always_ff @(posedge clk) begin
    case (state)
      lrts_pkg::S_IDLE: begin
        if (in_acc) begin
          op_q       <= operation;
          r_status   <= lrts_pkg::ST_OK;
          r_switched <= 1'b0;
          r_chosen   <= '0;
          r_created  <= '0;
          r_fvalid   <= 1'b0;
          r_freed    <= '0;
          pass       <= 1'b0;
          target     <= h_slot;
          list_susp  <= is_susp[h_slot];
          push_susp  <= !is_susp[h_slot];
          cont       <= (operation == lrts_pkg::OP_KILL) ? lrts_pkg::C_FREE
                                                         : lrts_pkg::C_PUSH;
          if (operation == lrts_pkg::OP_CREATE) begin
            target    <= free_idx;
            push_susp <= 1'b0;
            r_created <= free_idx;
            if (!free_found) r_status <= lrts_pkg::ST_FULL;
          end
          if ((operation == lrts_pkg::OP_SUSPEND || operation == lrts_pkg::OP_RESUME ||
               operation == lrts_pkg::OP_KILL) && !h_ok) begin
            r_status <= lrts_pkg::ST_BAD_HANDLE;
          end
          if (operation == lrts_pkg::OP_KILL && h_ok && !is_susp[h_slot]) begin
            r_fvalid <= 1'b1;
            r_freed  <= h_slot;
          end
        end
      end
      lrts_pkg::S_PK_START: begin
        node  <= running_first;
        found <= 1'b0;
      end
      lrts_pkg::S_PK_CMP: begin
        if (!found || tk_rdata < best_tick) begin
          found     <= 1'b1;
          best      <= SW'(node);
          best_tick <= tk_rdata;
        end
        node <= nx_rdata;
      end
      lrts_pkg::S_PK_END: begin
        if (is_term[pick_slot] && !pass) begin
          pass      <= 1'b1;
          target    <= pick_slot;
          list_susp <= is_susp[pick_slot];
          cont      <= lrts_pkg::C_PICK;
          r_fvalid  <= 1'b1;
          r_freed   <= pick_slot;
        end else begin
          r_switched <= 1'b1;
          r_chosen   <= pick_slot;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == lrts_pkg::S_RESP && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lrts_pkg::S_RESP && (!out_valid || !out_stall)) begin
      status       <= r_status;
      switched     <= r_switched;
      chosen_task  <= lrts_pkg::TASK_W'(r_chosen);
      created_task <= lrts_pkg::TASK_W'(r_created);
      freed_valid  <= r_fvalid;
      freed_task   <= lrts_pkg::TASK_W'(r_freed);
    end
  end

  // Checks
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall) else $error("transaction accepted while busy");

  a_idle_slot_used: assert property (@(posedge clk) disable iff (rst)
    slot_used[0] && !is_susp[0] && !is_term[0]) else $error("idle slot disturbed");

  a_susp_used: assert property (@(posedge clk) disable iff (rst)
    (is_susp & ~slot_used) == '0) else $error("suspended flag on free slot");

  a_term_used: assert property (@(posedge clk) disable iff (rst)
    (is_term & ~slot_used) == '0) else $error("terminating flag on free slot");

endmodule

FILE: design/lrts_ram.sv
// Single-port-write, single-port-read memory with registered read data
module lrts_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
